// ----- rtl/core/msst_pkg.sv -----
// Shared types, codes and constants of the multi-slot software timer.
package msst_pkg;

	localparam int unsigned SLOTS_DEF    = 8;
	localparam int unsigned MAX_RESULTS  = 8;
	localparam int unsigned SLOT_FIELD_W = 3;
	localparam int unsigned TIME_W       = 32;
	localparam int unsigned RES_CNT_W    = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] OP_SET    = 2'd0;
	localparam logic [1:0] OP_CANCEL = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	localparam logic [1:0] KIND_SET     = 2'd0;
	localparam logic [1:0] KIND_CANCEL  = 2'd1;
	localparam logic [1:0] KIND_EXPIRED = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SLOT  = 2'd1;
	localparam logic [1:0] ST_BAD_SLOT = 2'd2;

	typedef struct packed {
		logic [1:0]              operation;
		logic [TIME_W-1:0]       interval_ticks;
		logic                    repeat_req;
		logic [SLOT_FIELD_W-1:0] slot_index;
		logic [TIME_W-1:0]       now;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [1:0]              status;
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    last;
		logic                    base_tick_running;
	} out_item_t;

	// Request as it travels from cell to cell
	typedef struct packed {
		logic                 vld;
		in_item_t             item;
		logic                 done;
		logic [RES_CNT_W-1:0] n_exp;
	} chain_req_t;

	// Action taken by one cell in one cycle
	typedef struct packed {
		logic                    vld;
		logic [1:0]              kind;
		logic [SLOT_FIELD_W-1:0] slot;
		logic                    inc;
		logic                    dec;
	} cell_evt_t;

endpackage

// ----- rtl/core/multi_slot_software_timer.sv -----
// Top level of the multi-slot software timer: cell chain, busy count and result output.
//
// Usage: drive request and raise start; the request is taken at a rising edge
// with start high and busy low. Operations: set (take the lowest free slot),
// cancel (free one slot) and tick (report every busy slot whose deadline is
// reached, up to eight per tick, in slot order).
// The request walks the row of SLOTS slot cells, one cell per cycle, so busy
// stays high until the request leaves the last cell, and no new request is taken
// before then. Results appear on result, each marked by strobe for one cycle;
// set and cancel give one result, a tick gives zero or more, and the final
// one carries last.
// A finished result is held back by one slot action so that last can be set,
// so results of a tick are not on consecutive cycles in general.
// The receiver cannot stall: every strobed result must be taken that cycle.
// Reset (arst_n low) frees all slots, clears the busy count and drops any
// request in flight; no result is produced for it.
module multi_slot_software_timer import msst_pkg::*; #(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  request,
	output logic      strobe,
	output out_item_t result
);

	localparam int unsigned CNT_W = $clog2(SLOTS + 1);

	chain_req_t chain [SLOTS+1];
	cell_evt_t  evt [SLOTS];
	cell_evt_t  evt_any;
	chain_req_t tail;

	logic             busy_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             pend_vld_q;
	logic             pend_vld_d;
	out_item_t        pend_q;
	out_item_t        pend_d;
	logic             strobe_q;
	logic             strobe_d;
	out_item_t        result_q;
	out_item_t        result_d;
	logic             accept;

	assign accept = start && !busy_q;

	always_comb begin
		chain[0]       = '0;
		chain[0].vld   = accept;
		chain[0].item  = request;
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_cell
		msst_cell #(
			.CELL_IDX(g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.req_in (chain[g]),
			.req_out(chain[g+1]),
			.evt    (evt[g])
		);
	end

	assign tail = chain[SLOTS];

	always_comb begin
		evt_any = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (evt[i].vld) begin
				evt_any = evt[i];
			end
		end

		count_d = count_q + CNT_W'(evt_any.inc)
			- CNT_W'(evt_any.dec && count_q != '0);

		pend_vld_d = pend_vld_q;
		pend_d     = pend_q;
		strobe_d   = 1'b0;
		result_d   = pend_q;

		// hold each action's result until the next action or the end of the walk
		if (evt_any.vld) begin
			if (pend_vld_q) begin
				strobe_d      = 1'b1;
				result_d.last = 1'b0;
			end
			pend_vld_d                = 1'b1;
			pend_d.kind               = evt_any.kind;
			pend_d.status             = ST_OK;
			pend_d.slot               = evt_any.slot;
			pend_d.last               = 1'b1;
			pend_d.base_tick_running  = count_d != '0;
		end else if (tail.vld) begin
			pend_vld_d = 1'b0;
			if (pend_vld_q) begin
				strobe_d      = 1'b1;
				result_d.last = 1'b1;
			end else if (!tail.done && tail.item.operation == OP_SET) begin
				strobe_d                   = 1'b1;
				result_d.kind              = KIND_SET;
				result_d.status            = ST_NO_SLOT;
				result_d.slot              = '0;
				result_d.last              = 1'b1;
				result_d.base_tick_running = count_q != '0;
			end else if (!tail.done && tail.item.operation == OP_CANCEL) begin
				strobe_d                   = 1'b1;
				result_d.kind              = KIND_CANCEL;
				result_d.status            = ST_BAD_SLOT;
				result_d.slot              = tail.item.slot_index;
				result_d.last              = 1'b1;
				result_d.base_tick_running = count_q != '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			count_q    <= '0;
			pend_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.vld) begin
				busy_q <= 1'b0;
			end
			count_q    <= count_d;
			pend_vld_q <= pend_vld_d;
			strobe_q   <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_q   <= pend_d;
		result_q <= result_d;
	end

	assign busy   = busy_q;
	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// ----- rtl/core/msst_cell.sv -----
// One timer slot: holds busy flag, deadline and period, acts on the passing request.
module msst_cell import msst_pkg::*; #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  chain_req_t req_in,
	output chain_req_t req_out,
	output cell_evt_t  evt
);

	localparam bit                      ID_FITS = CELL_IDX < (1 << SLOT_FIELD_W);
	localparam logic [SLOT_FIELD_W-1:0] ID_LO   = SLOT_FIELD_W'(CELL_IDX);

	logic              busy_q;
	logic              busy_d;
	logic [TIME_W-1:0] deadline_q;
	logic [TIME_W-1:0] deadline_d;
	logic [TIME_W-1:0] period_q;
	logic [TIME_W-1:0] period_d;
	chain_req_t        req_q;
	chain_req_t        fwd;
	logic [TIME_W-1:0] sum;
	logic              due;
	logic              is_set;

	always_comb begin
		is_set = req_in.item.operation == OP_SET;
		// one adder: now + interval on set, deadline + period on reload
		sum = (is_set ? req_in.item.now : deadline_q)
			+ (is_set ? req_in.item.interval_ticks : period_q);
		due = busy_q && (req_in.item.now >= deadline_q)
			&& (req_in.n_exp < RES_CNT_W'(MAX_RESULTS));

		busy_d     = busy_q;
		deadline_d = deadline_q;
		period_d   = period_q;
		fwd        = req_in;
		evt        = '0;

		if (req_in.vld) begin
			case (req_in.item.operation)
				OP_SET: begin
					if (!req_in.done && !busy_q) begin
						busy_d     = 1'b1;
						deadline_d = sum;
						period_d   = req_in.item.repeat_req ? req_in.item.interval_ticks : '0;
						fwd.done   = 1'b1;
						evt.vld    = 1'b1;
						evt.kind   = KIND_SET;
						evt.slot   = ID_LO;
						evt.inc    = 1'b1;
					end
				end
				OP_CANCEL: begin
					if (ID_FITS && req_in.item.slot_index == ID_LO && busy_q) begin
						busy_d   = 1'b0;
						fwd.done = 1'b1;
						evt.vld  = 1'b1;
						evt.kind = KIND_CANCEL;
						evt.slot = ID_LO;
						evt.dec  = 1'b1;
					end
				end
				OP_TICK: begin
					if (due) begin
						// reload a periodic slot, drop a one-shot slot
						if (period_q != '0) begin
							deadline_d = sum;
						end else begin
							busy_d = 1'b0;
						end
						fwd.n_exp = req_in.n_exp + RES_CNT_W'(1);
						evt.vld   = 1'b1;
						evt.kind  = KIND_EXPIRED;
						evt.slot  = ID_LO;
						evt.dec   = period_q == '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			req_q  <= '0;
		end else begin
			busy_q <= busy_d;
			req_q  <= fwd;
		end
	end

	always_ff @(posedge clk) begin
		deadline_q <= deadline_d;
		period_q   <= period_d;
	end

	assign req_out = req_q;

endmodule

// ----- rtl/core/msst_checker.sv -----
// Port-level checks of the multi-slot software timer, bound to the top level.
module msst_checker import msst_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_item_t  request,
	input logic      strobe,
	input out_item_t result
);

	// an accepted request keeps the block working in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// set and cancel replies are single results
	a_single_reply: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.kind != KIND_EXPIRED |-> result.last)
		else $error("set or cancel reply without last");

	// more results to come means the request is still in progress
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final result after the block went idle");

	// a full table implies busy slots
	a_full_running: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.status == ST_NO_SLOT |-> result.base_tick_running)
		else $error("no free slot reported while no slot is busy");

endmodule

bind multi_slot_software_timer msst_checker u_msst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.request(request),
	.strobe (strobe),
	.result (result)
);
